// ----- rtl/sck_pkg.sv -----
// types and constants shared by the soft chroma key and crop pipeline
// no dependencies; compile first

package sck_pkg;

  localparam int CH_W      = 8;
  localparam int POS_W     = 12;
  localparam int DIM_W     = 13;
  localparam int DIST_W    = 17;
  localparam int COLOR_W   = 24;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [DIM_W-1:0]  MAX_DIM       = 13'd4096;
  localparam logic [DIST_W-1:0] KEY_MAX_RESET = 17'd65536;
  localparam logic [CH_W-1:0]   ALPHA_MAX     = 8'd255;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_LEFT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_RIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_TOP    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CROP_BOTTOM = 3'd7;

  // distance arithmetic: q = floor(S * 2^(2F) / NORM_DEN), d = isqrt(q)
  localparam int DIST_FRAC_BITS = 16;
  localparam int NORM_DEN       = 195075;
  localparam int SUM_W          = 18;
  localparam int Q_W            = 2 * DIST_FRAC_BITS + 1;
  localparam int RECIP_W        = 34;
  localparam int PROD_W         = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << (2 * DIST_FRAC_BITS + SUM_W)) / 64'(NORM_DEN));

  localparam int ISQ_STEPS  = (Q_W + 1) / 2;
  localparam int ISQ_PER    = 3;
  localparam int ISQ_STAGES = (ISQ_STEPS + ISQ_PER - 1) / ISQ_PER;
  localparam int QPAD_W     = 2 * ISQ_STEPS;
  localparam int REM_W      = DIST_W + 3;

  // alpha divider: 8 quotient bits, two per stage
  localparam int NUM_W      = DIST_W + CH_W;
  localparam int DIV_PER    = 2;
  localparam int DIV_STAGES = CH_W / DIV_PER;

  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  alpha_in;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0]  red_out;
    logic [CH_W-1:0]  green_out;
    logic [CH_W-1:0]  blue_out;
    logic [CH_W-1:0]  alpha_out;
    logic [POS_W-1:0] out_x;
    logic [POS_W-1:0] out_y;
    logic [DIM_W-1:0] out_width;
    logic [DIM_W-1:0] out_height;
    logic             row_end;
    logic             frame_end;
  } result_t;

  // pixel as it travels after cropping
  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [CH_W-1:0]  alpha_in;
    logic [POS_W-1:0] out_x;
    logic [POS_W-1:0] out_y;
    logic [DIM_W-1:0] out_width;
    logic [DIM_W-1:0] out_height;
    logic             row_end;
    logic             frame_end;
  } side_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] value;
  } cfg_write_t;

  typedef struct packed {
    logic              enable;
    logic [COLOR_W-1:0] color;
    logic [DIST_W-1:0] ramp_lo;
    logic [DIST_W-1:0] ramp_hi;
  } key_cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0] left;
    logic [DIM_W-1:0] right;
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] bottom;
  } crop_cfg_t;

endpackage

// ----- rtl/sck_chan_if.sv -----
// valid/ready channel carrying one payload beat
// payload type given by parameter; no other dependencies

interface sck_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/soft_chroma_key_crop.sv -----
// top level of the soft chroma key with crop window
// depends on sck_pkg, sck_chan_if, sck_crop, sck_dist, sck_alpha

// Takes one pixel beat per clock and gives at most one result beat per pixel,
// also one per clock when the sink keeps ready high. Pixels outside the crop
// window, or of a frame whose cropped width or height is zero, give no beat.
// An accepted pixel passes one crop stage, ten distance stages (squared
// distance, two multiplies and a correction for the constant division, six
// square-root stages of up to three bits each) and six alpha stages (ramp
// selection, four divider stages of two quotient bits each, output register).
// Every stage holds its own valid bit and empty stages fill while the output
// is stalled, so a waiting result does not block intake until the pipeline is
// full. Configuration registers are written through the cfg channel, which is
// always ready; they are to be written only while no pixel is in flight. There
// are no memories and no clearing pass after reset.

module soft_chroma_key_crop (
  input logic      clk,
  input logic      rst,
  sck_chan_if.sink   pixel,
  sck_chan_if.source result,
  sck_chan_if.sink   cfg
);
  import sck_pkg::*;

  key_cfg_t  key;
  crop_cfg_t crop;

  // configuration registers, always accepted
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key.enable  <= 1'b0;
      key.color   <= '0;
      key.ramp_lo <= '0;
      key.ramp_hi <= KEY_MAX_RESET;
      crop        <= '0;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_KEY_ENABLE:  key.enable  <= cfg.data.value[0];
        REG_KEY_COLOR:   key.color   <= cfg.data.value[COLOR_W-1:0];
        REG_KEY_MIN:     key.ramp_lo <= cfg.data.value[DIST_W-1:0];
        REG_KEY_MAX:     key.ramp_hi <= cfg.data.value[DIST_W-1:0];
        REG_CROP_LEFT:   crop.left   <= cfg.data.value[DIM_W-1:0];
        REG_CROP_RIGHT:  crop.right  <= cfg.data.value[DIM_W-1:0];
        REG_CROP_TOP:    crop.top    <= cfg.data.value[DIM_W-1:0];
        REG_CROP_BOTTOM: crop.bottom <= cfg.data.value[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // crop -> distance
  logic              c_valid, c_ready;
  side_t             c_side;
  // distance -> alpha
  logic              d_valid, d_ready;
  side_t             d_side;
  logic [DIST_W-1:0] d_dist;

  sck_crop u_crop (
    .clk       (clk),
    .rst       (rst),
    .crop      (crop),
    .in_valid  (pixel.valid),
    .in_ready  (pixel.ready),
    .in_pix    (pixel.data),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_side  (c_side)
  );

  sck_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .key_color (key.color),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .in_side   (c_side),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_side  (d_side),
    .dnorm     (d_dist)
  );

  // alpha stage drives the result beat straight from its output register
  sck_alpha u_alpha (
    .clk       (clk),
    .rst       (rst),
    .key       (key),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_side   (d_side),
    .dnorm     (d_dist),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_res   (result.data)
  );
endmodule

// ----- rtl/sck_crop.sv -----
// crop window stage: cropped size, cropped position, row and frame end flags
// depends on sck_pkg

module sck_crop (
  input  logic               clk,
  input  logic               rst,
  input  sck_pkg::crop_cfg_t crop,
  input  logic               in_valid,
  output logic               in_ready,
  input  sck_pkg::pixel_t    in_pix,
  output logic               out_valid,
  input  logic               out_ready,
  output sck_pkg::side_t     out_side
);
  import sck_pkg::*;

  logic [DIM_W-1:0] fw, fh, nw, nh;
  logic [DIM_W:0]   sum_w, sum_h;
  logic [DIM_W-1:0] ox_full, oy_full;
  logic             keep_x, keep_y, keep, row_last;
  logic             vld;
  side_t            side;

  always_comb begin
    fw = (in_pix.frame_width > MAX_DIM) ? MAX_DIM : in_pix.frame_width;
    fh = (in_pix.frame_height > MAX_DIM) ? MAX_DIM : in_pix.frame_height;
    sum_w = {1'b0, crop.left} + {1'b0, crop.right};
    sum_h = {1'b0, crop.top} + {1'b0, crop.bottom};
    nw = fw - ((sum_w < {1'b0, fw}) ? sum_w[DIM_W-1:0] : fw);
    nh = fh - ((sum_h < {1'b0, fh}) ? sum_h[DIM_W-1:0] : fh);
    ox_full = {1'b0, in_pix.pos_x} - crop.left;
    oy_full = {1'b0, in_pix.pos_y} - crop.top;
    keep_x = ({1'b0, in_pix.pos_x} >= crop.left) && (ox_full < nw);
    keep_y = ({1'b0, in_pix.pos_y} >= crop.top) && (oy_full < nh);
    keep = (nw != '0) && (nh != '0) && keep_x && keep_y;
    row_last = (ox_full == nw - 1'b1);
  end

  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      side.red        <= in_pix.red;
      side.green      <= in_pix.green;
      side.blue       <= in_pix.blue;
      side.alpha_in   <= in_pix.alpha_in;
      side.out_x      <= ox_full[POS_W-1:0];
      side.out_y      <= oy_full[POS_W-1:0];
      side.out_width  <= nw;
      side.out_height <= nh;
      side.row_end    <= row_last;
      side.frame_end  <= row_last && (oy_full == nh - 1'b1);
    end
  end

  assign out_valid = vld;
  assign out_side  = side;
endmodule

// ----- rtl/sck_dist.sv -----
// normalised colour distance pipeline: squared distance, reciprocal
// multiply with correction, then a pipelined digit-by-digit square root; uses sck_pkg

module sck_dist (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [sck_pkg::COLOR_W-1:0] key_color,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sck_pkg::side_t              in_side,
  output logic                        out_valid,
  input  logic                        out_ready,
  output sck_pkg::side_t              out_side,
  output logic [sck_pkg::DIST_W-1:0]  dnorm
);
  import sck_pkg::*;

  localparam int NST = 4 + ISQ_STAGES;

  logic [NST-1:0] v, adv, v_in;
  side_t          side_r [NST];

  assign adv[NST-1] = !v[NST-1] || out_ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_adv
    assign adv[k] = !v[k] || adv[k+1];
  end
  assign in_ready = adv[0];
  assign v_in = {v[NST-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (adv[k]) v[k] <= v_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) side_r[0] <= in_side;
    for (int k = 1; k < NST; k++) begin
      if (adv[k]) side_r[k] <= side_r[k-1];
    end
  end

  // squared distance
  logic [CH_W-1:0]  dr, dg, db;
  logic [SUM_W-1:0] sum_s0, sum_s1, sum_s2;

  always_comb begin
    dr = (in_side.red >= key_color[23:16]) ? in_side.red - key_color[23:16]
                                           : key_color[23:16] - in_side.red;
    dg = (in_side.green >= key_color[15:8]) ? in_side.green - key_color[15:8]
                                            : key_color[15:8] - in_side.green;
    db = (in_side.blue >= key_color[7:0]) ? in_side.blue - key_color[7:0]
                                          : key_color[7:0] - in_side.blue;
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      sum_s0 <= SUM_W'(dr) * SUM_W'(dr) + SUM_W'(dg) * SUM_W'(dg) +
                SUM_W'(db) * SUM_W'(db);
    end
  end

  // quotient estimate, never more than one below the true value
  logic [PROD_W-1:0] est;
  logic [Q_W-1:0]    q0_s1, q0_s2, q_s3;
  logic [PROD_W-1:0] qn_s2, resid;

  assign est = PROD_W'(sum_s0) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      q0_s1  <= est[SUM_W +: Q_W];
      sum_s1 <= sum_s0;
    end
    if (adv[2]) begin
      qn_s2  <= PROD_W'(q0_s1) * PROD_W'(NORM_DEN);
      q0_s2  <= q0_s1;
      sum_s2 <= sum_s1;
    end
  end

  assign resid = (PROD_W'(sum_s2) << (2 * DIST_FRAC_BITS)) - qn_s2;

  always_ff @(posedge clk) begin
    if (adv[3]) q_s3 <= q0_s2 + Q_W'(resid >= PROD_W'(NORM_DEN));
  end

  // square root, up to ISQ_PER result bits per stage
  logic [REM_W-1:0]  rem_r  [ISQ_STAGES-1];
  logic [DIST_W-1:0] root_r [ISQ_STAGES];
  logic [QPAD_W-1:0] qs_r   [ISQ_STAGES-1];

  for (genvar j = 0; j < ISQ_STAGES; j++) begin : g_isq
    logic [REM_W-1:0]  rem_i, rem_c;
    logic [DIST_W-1:0] root_i, root_c;
    logic [QPAD_W-1:0] qs_i, qs_c;

    if (j == 0) begin : g_first
      assign rem_i  = '0;
      assign root_i = '0;
      assign qs_i   = QPAD_W'(q_s3);
    end else begin : g_next
      assign rem_i  = rem_r[j-1];
      assign root_i = root_r[j-1];
      assign qs_i   = qs_r[j-1];
    end

    always_comb begin
      logic [DIST_W+1:0] trial;
      rem_c  = rem_i;
      root_c = root_i;
      qs_c   = qs_i;
      trial  = '0;
      for (int t = 0; t < ISQ_PER; t++) begin
        if (j * ISQ_PER + t < ISQ_STEPS) begin
          rem_c = {rem_c[REM_W-3:0], qs_c[QPAD_W-1 -: 2]};
          qs_c  = qs_c << 2;
          trial = {root_c, 2'b01};
          if (rem_c >= REM_W'(trial)) begin
            rem_c  = rem_c - REM_W'(trial);
            root_c = {root_c[DIST_W-2:0], 1'b1};
          end else begin
            root_c = {root_c[DIST_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[4+j]) root_r[j] <= root_c;
    end

    // remainder and remaining radicand only matter to a later stage
    if (j < ISQ_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv[4+j]) begin
          rem_r[j] <= rem_c;
          qs_r[j]  <= qs_c;
        end
      end
    end
  end

  assign out_valid = v[NST-1];
  assign out_side  = side_r[NST-1];
  assign dnorm     = root_r[ISQ_STAGES-1];
endmodule

// ----- rtl/sck_alpha.sv -----
// key alpha: ramp selection, pipelined restoring divider for the soft edge,
// and the output register; uses sck_pkg

module sck_alpha (
  input  logic                       clk,
  input  logic                       rst,
  input  sck_pkg::key_cfg_t          key,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  sck_pkg::side_t             in_side,
  input  logic [sck_pkg::DIST_W-1:0] dnorm,
  output logic                       out_valid,
  input  logic                       out_ready,
  output sck_pkg::result_t           out_res
);
  import sck_pkg::*;

  localparam int NST = 2 + DIV_STAGES;

  logic [NST-1:0] v, adv, v_in;
  side_t          side_r [NST-1];

  assign adv[NST-1] = !v[NST-1] || out_ready;
  for (genvar k = 0; k < NST - 1; k++) begin : g_adv
    assign adv[k] = !v[k] || adv[k+1];
  end
  assign in_ready = adv[0];
  assign v_in = {v[NST-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (adv[k]) v[k] <= v_in[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) side_r[0] <= in_side;
    for (int k = 1; k < NST - 1; k++) begin
      if (adv[k]) side_r[k] <= side_r[k-1];
    end
  end

  // ramp selection
  logic              forced;
  logic [CH_W-1:0]   fval;
  logic [DIST_W-1:0] n, den;

  always_comb begin
    forced = 1'b1;
    fval   = '0;
    n      = '0;
    den    = '0;
    if (!key.enable) begin
      fval = in_side.alpha_in;
    end else if (key.ramp_hi == key.ramp_lo) begin
      fval = (dnorm >= key.ramp_hi) ? ALPHA_MAX : '0;
    end else if (key.ramp_hi > key.ramp_lo) begin
      if (dnorm <= key.ramp_lo) begin
        fval = '0;
      end else if (dnorm >= key.ramp_hi) begin
        fval = ALPHA_MAX;
      end else begin
        forced = 1'b0;
        n   = dnorm - key.ramp_lo;
        den = key.ramp_hi - key.ramp_lo;
      end
    end else begin
      if (dnorm >= key.ramp_lo) begin
        fval = '0;
      end else if (dnorm <= key.ramp_hi) begin
        fval = ALPHA_MAX;
      end else begin
        forced = 1'b0;
        n   = key.ramp_lo - dnorm;
        den = key.ramp_lo - key.ramp_hi;
      end
    end
  end

  logic              forced_r [NST-1];
  logic [CH_W-1:0]   fval_r   [NST-1];
  logic [DIST_W-1:0] den_r    [DIV_STAGES];
  logic [NUM_W-1:0]  p_r      [DIV_STAGES];
  logic [CH_W-1:0]   qt_r     [NST-1];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      forced_r[0] <= forced;
      fval_r[0]   <= fval;
      den_r[0]    <= den;
      p_r[0]      <= NUM_W'({n, {CH_W{1'b0}}}) - NUM_W'(n);
      qt_r[0]     <= '0;
    end
  end

  // restoring division, numerator below den * 256
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [NUM_W-1:0] p_c;
    logic [CH_W-1:0]  q_c;

    always_comb begin
      logic [NUM_W-1:0] sub;
      int               bi;
      p_c = p_r[j];
      q_c = qt_r[j];
      sub = '0;
      bi  = 0;
      for (int t = 0; t < DIV_PER; t++) begin
        bi  = CH_W - 1 - (j * DIV_PER + t);
        sub = NUM_W'(den_r[j]) << bi;
        if (p_c >= sub) begin
          p_c     = p_c - sub;
          q_c[bi] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv[1+j]) begin
        forced_r[j+1] <= forced_r[j];
        fval_r[j+1]   <= fval_r[j];
        qt_r[j+1]     <= q_c;
      end
    end

    // divisor and partial remainder are not needed after the last step
    if (j < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv[1+j]) begin
          den_r[j+1] <= den_r[j];
          p_r[j+1]   <= p_c;
        end
      end
    end
  end

  // output register
  result_t res;
  side_t   sd;

  assign sd = side_r[NST-2];

  always_ff @(posedge clk) begin
    if (adv[NST-1]) begin
      res.red_out    <= sd.red;
      res.green_out  <= sd.green;
      res.blue_out   <= sd.blue;
      res.alpha_out  <= forced_r[NST-2] ? fval_r[NST-2] : qt_r[NST-2];
      res.out_x      <= sd.out_x;
      res.out_y      <= sd.out_y;
      res.out_width  <= sd.out_width;
      res.out_height <= sd.out_height;
      res.row_end    <= sd.row_end;
      res.frame_end  <= sd.frame_end;
    end
  end

  assign out_valid = v[NST-1];
  assign out_res   = res;
endmodule

// ----- sim/tb_chan.sv -----
// testbench-side notes for the valid/ready channels
// no dependencies on the rtl folder; holds the beat counters type only

package tb_chan_pkg;
  typedef struct {
    int unsigned sent;
    int unsigned got;
  } beat_count_t;
endpackage

// ----- sim/tb_top.sv -----
// self-checking bench for soft_chroma_key_crop: directed table then random pixels
// depends on sck_pkg, sck_chan_if, tb_chan_pkg and the rtl of the block

module tb_top;
  import sck_pkg::*;
  import tb_chan_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  sck_chan_if #(.payload_t(pixel_t))     pix_ch ();
  sck_chan_if #(.payload_t(result_t))    res_ch ();
  sck_chan_if #(.payload_t(cfg_write_t)) cfg_ch ();

  soft_chroma_key_crop dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_ch.sink),
    .result (res_ch.source),
    .cfg    (cfg_ch.sink)
  );

  // shadow copy of the registers
  logic               sh_enable;
  logic [COLOR_W-1:0] sh_color;
  logic [DIST_W-1:0]  sh_min, sh_max;
  logic [DIM_W-1:0]   sh_left, sh_right, sh_top, sh_bottom;

  result_t     keyed_q[$];
  int          errors = 0;
  beat_count_t cnt;
  int          idle_cycles = 0;
  bit          calm = 0;        // no idling in the last part of the run
  bit          long_hold = 0;   // receiver held off for a long stretch
  int          n_fill = 0;
  bit          done_stim = 0;

  localparam int WATCHDOG = 2000;
  localparam int LATENCY  = 17;

  // floor(sqrt(S * 2^32 / 195075)) done exactly by bit-serial steps
  function automatic logic [DIST_W-1:0] norm_dist(input logic [CH_W-1:0] r, g, b);
    logic [63:0] dr, dg, db, s, q, res, bitv, v;
    dr = (r >= sh_color[23:16]) ? r - sh_color[23:16] : sh_color[23:16] - r;
    dg = (g >= sh_color[15:8]) ? g - sh_color[15:8] : sh_color[15:8] - g;
    db = (b >= sh_color[7:0]) ? b - sh_color[7:0] : sh_color[7:0] - b;
    s = dr * dr + dg * dg + db * db;
    q = (s << 32) / 64'd195075;
    v = q;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res[DIST_W-1:0];
  endfunction

  function automatic logic [CH_W-1:0] ramp_alpha(input logic [DIST_W-1:0] d);
    logic [31:0] num;
    if (sh_max == sh_min) return (d >= sh_max) ? ALPHA_MAX : 8'd0;
    if (sh_max > sh_min) begin
      if (d <= sh_min) return 8'd0;
      if (d >= sh_max) return ALPHA_MAX;
      num = (32'(d) - sh_min) * 255 / (32'(sh_max) - sh_min);
    end else begin
      if (d >= sh_min) return 8'd0;
      if (d <= sh_max) return ALPHA_MAX;
      num = (32'(sh_min) - d) * 255 / (32'(sh_min) - sh_max);
    end
    return num[7:0];
  endfunction

  function automatic logic [DIM_W-1:0] cropped(input logic [DIM_W-1:0] full,
                                              input logic [DIM_W-1:0] a, bb);
    logic [14:0] f, sum;
    f = (full > MAX_DIM) ? MAX_DIM : full;
    sum = a + bb;
    return DIM_W'(f - ((sum < f) ? sum : f));
  endfunction

  // works out the kept pixel, if any
  function automatic bit key_and_crop(input pixel_t p, output result_t o);
    logic [DIM_W-1:0] nw, nh;
    logic [13:0] ox, oy;
    nw = cropped(p.frame_width, sh_left, sh_right);
    nh = cropped(p.frame_height, sh_top, sh_bottom);
    o = '0;
    if (nw == 0 || nh == 0) return 0;
    if (p.pos_x < sh_left || p.pos_x - sh_left >= nw) return 0;
    if (p.pos_y < sh_top || p.pos_y - sh_top >= nh) return 0;
    ox = p.pos_x - sh_left;
    oy = p.pos_y - sh_top;
    o.red_out = p.red;
    o.green_out = p.green;
    o.blue_out = p.blue;
    o.alpha_out = sh_enable ? ramp_alpha(norm_dist(p.red, p.green, p.blue)) : p.alpha_in;
    o.out_x = ox[POS_W-1:0];
    o.out_y = oy[POS_W-1:0];
    o.out_width = nw;
    o.out_height = nh;
    o.row_end = (ox == 14'(nw) - 14'd1);
    o.frame_end = (ox == 14'(nw) - 14'd1) && (oy == 14'(nh) - 14'd1);
    return 1;
  endfunction

  // register write through the cfg channel, shadow updated on the beat
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= '{index: idx, value: val};
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_KEY_ENABLE:  sh_enable = val[0];
      REG_KEY_COLOR:   sh_color = val;
      REG_KEY_MIN:     sh_min = val[DIST_W-1:0];
      REG_KEY_MAX:     sh_max = val[DIST_W-1:0];
      REG_CROP_LEFT:   sh_left = val[DIM_W-1:0];
      REG_CROP_RIGHT:  sh_right = val[DIM_W-1:0];
      REG_CROP_TOP:    sh_top = val[DIM_W-1:0];
      REG_CROP_BOTTOM: sh_bottom = val[DIM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // drain then let the pipe settle, so a dropped pixel is not still in flight
  task automatic wait_idle();
    while (keyed_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  task automatic load_key(input bit en, input logic [23:0] col,
                          input logic [DIST_W-1:0] mn, mx);
    wait_idle();
    write_reg(REG_KEY_ENABLE, {23'd0, en});
    write_reg(REG_KEY_COLOR, col);
    write_reg(REG_KEY_MIN, 24'(mn));
    write_reg(REG_KEY_MAX, 24'(mx));
  endtask

  task automatic load_crop(input logic [DIM_W-1:0] l, r, t, bt);
    wait_idle();
    write_reg(REG_CROP_LEFT, 24'(l));
    write_reg(REG_CROP_RIGHT, 24'(r));
    write_reg(REG_CROP_TOP, 24'(t));
    write_reg(REG_CROP_BOTTOM, 24'(bt));
  endtask

  // offers one pixel beat, with a random gap before it unless calm
  task automatic send_pixel(input pixel_t p);
    result_t o;
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      pix_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5) - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_ch.valid <= 1'b1;
    pix_ch.data <= p;
    do @(posedge clk); while (!pix_ch.ready);
    if (key_and_crop(p, o)) keyed_q.insert(keyed_q.size(), o);
    cnt.sent++;
  endtask

  task automatic end_burst();
    @(negedge clk);
    pix_ch.valid <= 1'b0;
  endtask

  function automatic pixel_t rand_pixel(input bit in_frame);
    pixel_t p;
    p.red = 8'($urandom); p.green = 8'($urandom);
    p.blue = 8'($urandom); p.alpha_in = 8'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      p.frame_width = 13'($urandom_range(1, 8191));
      p.frame_height = 13'($urandom_range(0, 8191));
      p.pos_x = 12'($urandom); p.pos_y = 12'($urandom);
    end else begin
      p.frame_width = 13'($urandom_range(1, 40));
      p.frame_height = 13'($urandom_range(1, 40));
      if (in_frame) begin
        p.pos_x = 12'($urandom_range(0, p.frame_width - 1));
        p.pos_y = 12'($urandom_range(0, p.frame_height - 1));
      end else begin
        p.pos_x = 12'($urandom_range(0, 60));
        p.pos_y = 12'($urandom_range(0, 60));
      end
    end
    if ($urandom_range(0, 30) == 0) begin
      p.frame_width = 13'd4096; p.frame_height = 13'd4096;
      p.pos_x = 12'd4095; p.pos_y = 12'd4095;
    end
    return p;
  endfunction

  // receiver: random stalls, plus one long hold-off to back up the pipe
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (long_hold) begin
      res_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always begin
    @(posedge clk);
    if (n_fill == 1) begin
      long_hold = 1;
      repeat (60) @(posedge clk);
      long_hold = 0;
      n_fill = 2;
    end
  end

  // checker against the oldest expected beat
  always @(posedge clk) begin
    result_t e, a;
    if (!rst && res_ch.valid && res_ch.ready) begin
      a = res_ch.data;
      cnt.got++;
      if (keyed_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, a);
        errors++;
      end else begin
        e = keyed_q.pop_front();
        if (a.red_out !== e.red_out || a.green_out !== e.green_out ||
            a.blue_out !== e.blue_out)
          $display("%0t: rgb expected %h actual %h", $time,
                   {e.red_out, e.green_out, e.blue_out},
                   {a.red_out, a.green_out, a.blue_out});
        if (a.alpha_out !== e.alpha_out)
          $display("%0t: alpha expected %0d actual %0d", $time, e.alpha_out, a.alpha_out);
        if (a.out_x !== e.out_x || a.out_y !== e.out_y)
          $display("%0t: position expected %0d,%0d actual %0d,%0d", $time,
                   e.out_x, e.out_y, a.out_x, a.out_y);
        if (a.out_width !== e.out_width || a.out_height !== e.out_height)
          $display("%0t: size expected %0dx%0d actual %0dx%0d", $time,
                   e.out_width, e.out_height, a.out_width, a.out_height);
        if (a.row_end !== e.row_end || a.frame_end !== e.frame_end)
          $display("%0t: ends expected %b%b actual %b%b", $time,
                   e.row_end, e.frame_end, a.row_end, a.frame_end);
        if (a !== e) errors++;
      end
    end
  end

  // watchdog on cycles with no beat at all
  always @(posedge clk) begin
    if (rst || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || done_stim)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // directed rows: pixel, with an expected beat typed in where obvious
  typedef struct {
    pixel_t  px;
    bit      typed;   // expectation given here and checked against the predictor
    bit      kept;
    result_t res;
  } row_t;

  row_t table_rows[$];

  task automatic add_row(input row_t r);
    table_rows.insert(table_rows.size(), r);
  endtask

  task automatic run_table();
    result_t o;
    bit k;
    foreach (table_rows[i]) begin
      if (table_rows[i].typed) begin
        k = key_and_crop(table_rows[i].px, o);
        if (k != table_rows[i].kept || (k && o !== table_rows[i].res)) begin
          $display("%0t: table row %0d expected %h actual %h", $time, i,
                   table_rows[i].res, o);
          errors++;
        end
      end
      send_pixel(table_rows[i].px);
    end
    end_burst();
  endtask

  function automatic row_t mk(input logic [7:0] r, g, b, a,
                              input logic [11:0] x, y,
                              input logic [12:0] w, h);
    row_t t;
    t.px = '{red: r, green: g, blue: b, alpha_in: a, pos_x: x, pos_y: y,
             frame_width: w, frame_height: h};
    t.typed = 0; t.kept = 0; t.res = '0;
    return t;
  endfunction

  initial begin
    pixel_t p;
    row_t t;
    int n;
    cnt = '{0, 0};
    pix_ch.valid = 1'b0; pix_ch.data = '0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    sh_enable = 0; sh_color = '0; sh_min = '0; sh_max = KEY_MAX_RESET;
    sh_left = '0; sh_right = '0; sh_top = '0; sh_bottom = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // after reset: pass-through of alpha, no crop
    t = mk(8'hFF, 8'h00, 8'hFF, 8'h5A, 12'd0, 12'd0, 13'd1, 13'd1);
    t.typed = 1; t.kept = 1;
    t.res = '{8'hFF, 8'h00, 8'hFF, 8'h5A, 12'd0, 12'd0, 13'd1, 13'd1, 1'b1, 1'b1};
    add_row(t);
    t = mk(8'h00, 8'hFF, 8'h00, 8'hFF, 12'd4095, 12'd4095, 13'd4096, 13'd4096);
    t.typed = 1; t.kept = 1;
    t.res = '{8'h00, 8'hFF, 8'h00, 8'hFF, 12'd4095, 12'd4095, 13'd4096, 13'd4096,
              1'b1, 1'b1};
    add_row(t);
    // oversized frame taken as the maximum
    t = mk(8'h12, 8'h34, 8'h56, 8'h00, 12'd10, 12'd4095, 13'd8191, 13'd4096);
    t.typed = 1; t.kept = 1;
    t.res = '{8'h12, 8'h34, 8'h56, 8'h00, 12'd10, 12'd4095, 13'd4096, 13'd4096,
              1'b0, 1'b0};
    add_row(t);
    // zero height, and position outside the frame: dropped; then a kept corner pixel
    t = mk(8'h01, 8'h02, 8'h03, 8'h04, 12'd0, 12'd0, 13'd5, 13'd0);
    t.typed = 1; add_row(t);
    t = mk(8'h01, 8'h02, 8'h03, 8'h04, 12'd5, 12'd0, 13'd5, 13'd5);
    t.typed = 1; add_row(t);
    t = mk(8'h01, 8'h02, 8'h03, 8'h04, 12'd4, 12'd4, 13'd5, 13'd5);
    t.typed = 1; t.kept = 1;
    t.res = '{8'h01, 8'h02, 8'h03, 8'h04, 12'd4, 12'd4, 13'd5, 13'd5, 1'b1, 1'b1};
    add_row(t);
    run_table();

    // keying: full ramp, extreme colours against a black key
    load_key(1, 24'h000000, 17'd0, 17'd65536);
    table_rows.delete();
    t = mk(8'h00, 8'h00, 8'h00, 8'h77, 12'd0, 12'd0, 13'd2, 13'd1);
    t.typed = 1; t.kept = 1;
    t.res = '{8'h00, 8'h00, 8'h00, 8'h00, 12'd0, 12'd0, 13'd2, 13'd1, 1'b0, 1'b0};
    add_row(t);
    t = mk(8'hFF, 8'hFF, 8'hFF, 8'h00, 12'd1, 12'd0, 13'd2, 13'd1);
    t.typed = 1; t.kept = 1;
    t.res = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 12'd1, 12'd0, 13'd2, 13'd1, 1'b1, 1'b1};
    add_row(t);
    add_row(mk(8'h80, 8'h00, 8'h00, 8'h00, 12'd0, 12'd0, 13'd2, 13'd1));
    add_row(mk(8'h00, 8'hFF, 8'h40, 8'h00, 12'd0, 12'd0, 13'd2, 13'd1));
    run_table();

    // max equal to min, then max below min
    load_key(1, 24'hFFFFFF, 17'd30000, 17'd30000);
    table_rows.delete();
    add_row(mk(8'h00, 8'h00, 8'h00, 8'h00, 12'd0, 12'd0, 13'd1, 13'd1));
    add_row(mk(8'hF0, 8'hF0, 8'hF0, 8'h00, 12'd0, 12'd0, 13'd1, 13'd1));
    add_row(mk(8'h80, 8'h90, 8'h70, 8'h00, 12'd0, 12'd0, 13'd1, 13'd1));
    run_table();
    load_key(1, 24'h00FF00, 17'd50000, 17'd10000);
    table_rows.delete();
    add_row(mk(8'h00, 8'hFF, 8'h00, 8'h00, 12'd0, 12'd0, 13'd1, 13'd1));
    add_row(mk(8'h60, 8'hA0, 8'h30, 8'h00, 12'd0, 12'd0, 13'd1, 13'd1));
    add_row(mk(8'hFF, 8'h00, 8'hFF, 8'h00, 12'd0, 12'd0, 13'd1, 13'd1));
    run_table();

    // crop extremes: everything cropped away, then a small window
    load_crop(13'd4096, 13'd4096, 13'd4096, 13'd4096);
    table_rows.delete();
    t = mk(8'h01, 8'h01, 8'h01, 8'h01, 12'd4095, 12'd4095, 13'd4096, 13'd4096);
    t.typed = 1; add_row(t);
    run_table();
    load_crop(13'd2, 13'd3, 13'd1, 13'd2);
    table_rows.delete();
    add_row(mk(8'h11, 8'h22, 8'h33, 8'h44, 12'd1, 12'd1, 13'd8, 13'd5));
    add_row(mk(8'h11, 8'h22, 8'h33, 8'h44, 12'd2, 12'd1, 13'd8, 13'd5));
    add_row(mk(8'h11, 8'h22, 8'h33, 8'h44, 12'd4, 12'd2, 13'd8, 13'd5));
    add_row(mk(8'h11, 8'h22, 8'h33, 8'h44, 12'd5, 12'd2, 13'd8, 13'd5));
    add_row(mk(8'h11, 8'h22, 8'h33, 8'h44, 12'd4, 12'd3, 13'd8, 13'd5));
    run_table();

    // random phases, each with fresh register settings
    for (int ph = 0; ph < 12; ph++) begin
      load_key(1'($urandom_range(0, 1)), 24'($urandom),
               (ph % 4 == 0) ? 17'd65536 : 17'($urandom_range(0, 65536)),
               (ph % 4 == 1) ? 17'd0 : 17'($urandom_range(0, 65536)));
      if (ph == 11) load_crop(13'd0, 13'd0, 13'd0, 13'd0);
      else load_crop(13'($urandom_range(0, 6)), 13'($urandom_range(0, 6)),
                     13'($urandom_range(0, 6)), 13'($urandom_range(0, 6)));
      if (ph == 3) n_fill = 1;
      if (ph >= 10) calm = 1;
      n = (ph == 3) ? 120 : 75;
      for (int i = 0; i < n; i++) begin
        p = rand_pixel($urandom_range(0, 4) != 0);
        send_pixel(p);
      end
      end_burst();
      // after phase 5 only, sender pause until every expected beat has come
      if (ph == 5) while (keyed_q.size() != 0) @(posedge clk);
    end

    wait_idle();
    done_stim = 1;
    $display("tb_top: %0d pixels offered, %0d results checked over key, ramp and crop",
             cnt.sent, cnt.got);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
